>>> rtl/core/json_string_escaper_top_defines.svh
// Assertion macros used by the escaper back end.
`ifndef JSON_STRING_ESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset
`define JSE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define JSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/jse_pkg.sv
// Shared types, constants and helpers for the JSON string escaper.
package jse_pkg;

  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_BSL   = 7'h5C;
  localparam logic [6:0] CH_U     = 7'h75;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Lengths of the escape bodies
  localparam logic [3:0] LEN_U1 = 4'd6;
  localparam logic [3:0] LEN_U2 = 4'd12;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_PAIR,
    KIND_U1,
    KIND_U2
  } kind_t;

  // One classified item, ready for the character sequencer
  typedef struct packed {
    logic        starts;
    logic        ends;
    kind_t       kind;
    logic [6:0]  ch;     // literal char, or escape letter
    logic [15:0] hi;     // first \u value
    logic [15:0] lo;     // second \u value (surrogate pair only)
    logic [3:0]  len;    // body characters
    logic [3:0]  total;  // all characters incl. quotes
  } desc_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Lowercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) r = 7'h30 + {3'b000, n};
    else           r = 7'h57 + {3'b000, n};
    return r;
  endfunction

endpackage

>>> rtl/core/jse_front.sv
// Front end: accepts codepoints and classifies them into escape descriptors.
module jse_front (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // [20:0] codepoint, rest zero
  input  logic                  s_axis_tuser,   // [0] starts_string
  input  logic                  s_axis_tlast,   // ends_string
  input  jse_pkg::q_stat_t      q_stat,
  output logic                  push,
  output jse_pkg::desc_t        push_desc
);
  import jse_pkg::*;

  logic [20:0] cp;
  logic [20:0] v;
  logic [3:0]  flags;

  assign s_axis_tready = !q_stat.full;
  assign push          = s_axis_tvalid && !q_stat.full;

  // Clamp and offset for the surrogate split
  assign cp = (s_axis_tdata[20:0] > CP_MAX) ? CP_MAX : s_axis_tdata[20:0];
  assign v  = cp - SUPP_BASE;

  // Classify the codepoint
  always_comb begin
    push_desc        = '0;
    push_desc.starts = s_axis_tuser;
    push_desc.ends   = s_axis_tlast;
    push_desc.hi     = cp[15:0];
    push_desc.lo     = {6'b110111, v[9:0]};
    case (cp)
      21'h000000: begin
        push_desc.kind = KIND_NONE;
        push_desc.len  = 4'd0;
      end
      21'h000022: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h22; end
      21'h00005C: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h5C; end
      21'h00000A: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h6E; end
      21'h00000D: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h72; end
      21'h000009: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h74; end
      21'h000007: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h61; end
      21'h000008: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h62; end
      21'h00000C: begin push_desc.kind = KIND_PAIR; push_desc.ch = 7'h66; end
      default: begin
        if (cp inside {[21'd32 : 21'd126]}) begin
          push_desc.kind = KIND_CHAR;
          push_desc.ch   = cp[6:0];
        end else if (cp >= SUPP_BASE) begin
          push_desc.kind = KIND_U2;
          push_desc.hi   = {6'b110110, v[19:10]};
        end else begin
          push_desc.kind = KIND_U1;
        end
      end
    endcase

    // Body length follows the kind
    case (push_desc.kind)
      KIND_CHAR: push_desc.len = 4'd1;
      KIND_PAIR: push_desc.len = 4'd2;
      KIND_U1:   push_desc.len = LEN_U1;
      KIND_U2:   push_desc.len = LEN_U2;
      default:   push_desc.len = 4'd0;
    endcase
    flags           = {3'b000, s_axis_tuser} + {3'b000, s_axis_tlast};
    push_desc.total = push_desc.len + flags;
  end

endmodule

>>> rtl/core/jse_fifo.sv
// Short descriptor queue between the front and the back.
module jse_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jse_pkg::desc_t   push_desc,
  output jse_pkg::q_stat_t q_stat,
  input  logic             pop,
  output jse_pkg::desc_t   head
);
  import jse_pkg::*;

  desc_t          mem [QDEPTH];
  logic [QAW:0]   wr_ptr;
  logic [QAW:0]   rd_ptr;

  assign q_stat.empty = (wr_ptr == rd_ptr);
  assign q_stat.full  = (wr_ptr[QAW] != rd_ptr[QAW]) &&
                        (wr_ptr[QAW-1:0] == rd_ptr[QAW-1:0]);
  assign head         = mem[rd_ptr[QAW-1:0]];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr[QAW-1:0]] <= push_desc;
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

>>> rtl/core/jse_back.sv
// Back end: walks one descriptor and sends its characters, one per cycle while m_axis_tready does not stall the output.
`include "json_string_escaper_top_defines.svh"

module jse_back (
  input  logic             clk,
  input  logic             rst,
  input  jse_pkg::q_stat_t q_stat,
  input  jse_pkg::desc_t   head,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic             m_axis_tlast    // last_of_run
);
  import jse_pkg::*;

  logic       head_valid;
  logic       load;
  logic       emit;
  logic       at_last;
  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [3:0] b;
  logic [3:0] b_lo;
  logic [2:0] j;
  logic [15:0] val;
  logic [6:0] body_ch;
  logic [6:0] ch;

  assign head_valid = !q_stat.empty;
  assign load       = !m_axis_tvalid || m_axis_tready;
  assign emit       = head_valid && (head.total != 4'd0) && load;
  assign at_last    = (pos == head.total - 4'd1);
  assign pop        = head_valid && ((head.total == 4'd0) || (emit && at_last));

  // Position inside the body, and inside one \u escape
  assign b    = pos - {3'b000, head.starts};
  assign b_lo = b - LEN_U1;
  assign j    = (b >= LEN_U1) ? b_lo[2:0] : b[2:0];
  assign val  = (b >= LEN_U1) ? head.lo : head.hi;

  // Body character
  always_comb begin
    case (head.kind)
      KIND_CHAR: body_ch = head.ch;
      KIND_PAIR: body_ch = (b == 4'd0) ? CH_BSL : head.ch;
      KIND_U1, KIND_U2: begin
        case (j)
          3'd0:    body_ch = CH_BSL;
          3'd1:    body_ch = CH_U;
          3'd2:    body_ch = hex_char(val[15:12]);
          3'd3:    body_ch = hex_char(val[11:8]);
          3'd4:    body_ch = hex_char(val[7:4]);
          default: body_ch = hex_char(val[3:0]);
        endcase
      end
      default: body_ch = CH_QUOTE;
    endcase
  end

  // Opening quote, body, closing quote
  always_comb begin
    if (head.starts && pos == 4'd0) ch = CH_QUOTE;
    else if (b < head.len)          ch = body_ch;
    else                            ch = CH_QUOTE;
  end

  assign pos_next = pop ? 4'd0 : (emit ? pos + 4'd1 : pos);

  // Sequencer position
  always_ff @(posedge clk) begin
    if (rst) pos <= '0;
    else     pos <= pos_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {1'b0, ch};
      m_axis_tlast <= at_last;
    end
  end

  `JSE_ASSERT_NOW(a_pos_in_range, clk, rst, head_valid && head.total != 4'd0, pos < head.total, "position past end of item")
  `JSE_ASSERT_NOW(a_last_pops, clk, rst, emit && at_last, pop, "last character sent without releasing item")
  `JSE_ASSERT_NEXT(a_pop_shows_last, clk, rst, pop && head.total != 4'd0, m_axis_tvalid && m_axis_tlast, "finished item did not end with a last character")

endmodule

>>> rtl/core/json_string_escaper_top.sv
// Top level of the JSON string escaper: front, queue and back.
//
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tdata[20:0] codepoint, tuser starts_string,
//                                       tlast ends_string
//  m_axis   out  m_axis_tvalid/tready   tdata[6:0] out_char, tlast last_of_run
//
// Each item yields 0 to 14 output characters, which the back end sends one
// per transfer; an item with no characters is released from the queue without
// a transfer. The front takes an item every cycle while the four-entry queue has
// room, so it keeps accepting during output stalls.
// Reset (rst, synchronous) empties the queue and the output register.
module json_string_escaper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] codepoint, [23:21] zero
  input  logic        s_axis_tuser,   // [0] starts_string
  input  logic        s_axis_tlast,   // ends_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic        m_axis_tlast    // last_of_run
);
  import jse_pkg::*;

  q_stat_t q_stat;
  desc_t   push_desc;
  desc_t   head;
  logic    push;
  logic    pop;

  jse_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_stat        (q_stat),
    .push          (push),
    .push_desc     (push_desc)
  );

  jse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .q_stat    (q_stat),
    .pop       (pop),
    .head      (head)
  );

  jse_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
